// File: design/wavetable_sound_channel_macros.svh
// ----------------------------------------------------------------------------
// wavetable sound channel assertion macros
// shared property shapes for the channel's concurrent checks
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_SOUND_CHANNEL_MACROS_SVH
`define WAVETABLE_SOUND_CHANNEL_MACROS_SVH

// same-cycle implication, checked outside reset
`define WSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wsc_pkg.sv
// ----------------------------------------------------------------------------
// wsc_pkg
// codes, field types and the volume table of the wavetable sound channel
// ----------------------------------------------------------------------------
package wsc_pkg;

  typedef logic [2:0] action_t;
  typedef logic [2:0] reg_sel_t;

  // item kinds
  localparam action_t ACT_TICK     = 3'd0;
  localparam action_t ACT_LENGTH   = 3'd1;
  localparam action_t ACT_REG_WR   = 3'd2;
  localparam action_t ACT_DISABLE  = 3'd3;
  localparam action_t ACT_WAVE_WR  = 3'd4;

  // register selects
  localparam reg_sel_t REG_ENABLE    = 3'd0;
  localparam reg_sel_t REG_LENGTH    = 3'd1;
  localparam reg_sel_t REG_LEVEL     = 3'd2;
  localparam reg_sel_t REG_FREQ_LO   = 3'd3;
  localparam reg_sel_t REG_FREQ_CTRL = 3'd4;

  localparam int unsigned WAVE_DEPTH = 32;
  localparam int unsigned WAVE_AW    = 5;

  // volume multiplier: three quarters overrides the 2-bit code
  function automatic logic [2:0] level_factor(input logic [1:0] vol, input logic force_tq);
    logic [2:0] f;
    if (force_tq) begin
      f = 3'd3;
    end else begin
      unique case (vol)
        2'd0: f = 3'd0;
        2'd1: f = 3'd4;
        2'd2: f = 3'd2;
        2'd3: f = 3'd1;
        default: f = 3'd0;
      endcase
    end
    return f;
  endfunction

endpackage

// File: design/wavetable_sound_channel.sv
// ----------------------------------------------------------------------------
// wavetable sound channel
// two-bank 4-bit wave player with length counter and volume scaling
// ----------------------------------------------------------------------------
// usage:
//   the slave channel (s_*) takes one event per transfer: a sample tick, a
//   length clock, a register byte write, a disable, or a wave memory byte
//   write. the kind and register select ride in s_tuser, the byte and wave
//   address in s_tdata.
//   the master channel (m_*) returns exactly one result per event: the scaled
//   signed sample level, the channel-on flag, the 11-bit period code for an
//   external tick timer, and the bank being played.
// timing:
//   an event is held in an input register; when it is applied to the channel
//   state, its result is written to the output register and m_tvalid rises.
//   one event per cycle is sustained while m_tready stays high; the only
//   work per event is one wave memory read and a small multiply.
// stalls:
//   while m_tready is low one more event is taken into the input register,
//   then s_tready drops until the waiting result is transferred.
// reset:
//   rst clears all control state and the 32-byte wave memory at once; the
//   block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "wavetable_sound_channel_macros.svh"

module wavetable_sound_channel #(
  parameter int unsigned SAMPLES_PER_BANK = 32
) (
  input  logic        clk,
  input  logic        rst,
  // event input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [7:0] write_data, [12:8] wave_address, rest zero
  input  logic [5:0]  s_tuser,  // [2:0] action, [5:3] register_select
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // [7:0] sample_out, [8] channel_enabled,
                                // [19:9] period_code, [20] playing_bank, rest zero
);
  import wsc_pkg::*;

  localparam int unsigned PW = $clog2(SAMPLES_PER_BANK);
  localparam logic [PW:0] POS_WRAP = (PW + 1)'(SAMPLES_PER_BANK);

  // input register
  logic                in_valid;
  action_t             in_action;
  reg_sel_t            in_sel;
  logic [7:0]          in_data;
  logic [WAVE_AW-1:0]  in_addr;

  // output register
  logic                out_valid;
  logic [23:0]         out_data;

  // channel state
  logic [7:0]          wave_mem [WAVE_DEPTH];
  logic [PW-1:0]       position, position_next;
  logic [3:0]          nibble, nibble_next;
  logic                channel_on, channel_on_next;
  logic                dac_on, dac_on_next;
  logic                two_bank, two_bank_next;
  logic                bank_sel, bank_sel_next;
  logic [7:0]          length_reload, length_reload_next;
  logic [7:0]          length_count, length_count_next;
  logic [1:0]          volume, volume_next;
  logic                force_tq, force_tq_next;
  logic [10:0]         freq, freq_next;
  logic                length_en, length_en_next;

  logic                advance;
  logic                step;
  logic                s_accept;

  logic [WAVE_AW-1:0]  fetch_addr;
  logic [7:0]          fetch_pair;
  logic [PW:0]         pos_inc;
  logic [2:0]          factor;
  logic signed [4:0]   centered;
  logic signed [7:0]   scaled;
  logic signed [7:0]   sample;

  // handshake: the output register frees up when empty or taken
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;
  assign step     = in_valid && advance;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_accept || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_action <= s_tuser[2:0];
      in_sel    <= s_tuser[5:3];
      in_data   <= s_tdata[7:0];
      in_addr   <= s_tdata[12:8];
    end
  end

  // wave fetch: high nibble on even positions, bank offset wraps mod 32
  assign fetch_addr = {bank_sel, 4'b0000} + WAVE_AW'(position[PW-1:1]);
  assign fetch_pair = wave_mem[fetch_addr];
  assign pos_inc    = {1'b0, position} + {{PW{1'b0}}, 1'b1};

  always_comb begin
    position_next      = position;
    nibble_next        = nibble;
    channel_on_next    = channel_on;
    dac_on_next        = dac_on;
    two_bank_next      = two_bank;
    bank_sel_next      = bank_sel;
    length_reload_next = length_reload;
    length_count_next  = length_count;
    volume_next        = volume;
    force_tq_next      = force_tq;
    freq_next          = freq;
    length_en_next     = length_en;

    unique case (in_action)
      ACT_TICK: begin
        if (channel_on && dac_on) begin
          nibble_next = position[0] ? fetch_pair[3:0] : fetch_pair[7:4];
        end else begin
          nibble_next = 4'd0;
        end
        if (pos_inc >= POS_WRAP) begin
          position_next = '0;
          if (two_bank) begin
            bank_sel_next = !bank_sel;
          end
        end else begin
          position_next = pos_inc[PW-1:0];
        end
      end
      ACT_LENGTH: begin
        if (length_en && (length_count != 8'd0)) begin
          length_count_next = length_count - 8'd1;
          if (length_count == 8'd1) begin
            channel_on_next = 1'b0;
          end
        end
      end
      ACT_REG_WR: begin
        unique case (in_sel)
          REG_ENABLE: begin
            two_bank_next = in_data[5];
            bank_sel_next = in_data[6];
            dac_on_next   = in_data[7];
          end
          REG_LENGTH: begin
            length_reload_next = in_data;
          end
          REG_LEVEL: begin
            volume_next   = in_data[6:5];
            force_tq_next = in_data[7];
          end
          REG_FREQ_LO: begin
            freq_next = {freq[10:8], in_data};
          end
          REG_FREQ_CTRL: begin
            freq_next      = {in_data[2:0], freq[7:0]};
            length_en_next = in_data[6];
            // trigger restarts playback, even with the dac off
            if (in_data[7]) begin
              channel_on_next   = 1'b1;
              position_next     = '0;
              length_count_next = length_reload;
            end
          end
          default: begin
          end
        endcase
      end
      ACT_DISABLE: begin
        length_count_next = 8'd0;
        channel_on_next   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // level = (nibble - 8) * 4 * factor, from the updated state
  assign factor   = level_factor(volume_next, force_tq_next);
  assign centered = $signed({1'b0, nibble_next}) - 5'sd8;
  assign scaled   = $signed({{3{centered[4]}}, centered}) * $signed({5'b00000, factor});
  assign sample   = scaled <<< 2;

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      nibble        <= 4'd0;
      channel_on    <= 1'b0;
      dac_on        <= 1'b0;
      two_bank      <= 1'b0;
      bank_sel      <= 1'b0;
      length_reload <= 8'd0;
      length_count  <= 8'd0;
      volume        <= 2'd0;
      force_tq      <= 1'b0;
      freq          <= 11'd0;
      length_en     <= 1'b0;
    end else if (step) begin
      position      <= position_next;
      nibble        <= nibble_next;
      channel_on    <= channel_on_next;
      dac_on        <= dac_on_next;
      two_bank      <= two_bank_next;
      bank_sel      <= bank_sel_next;
      length_reload <= length_reload_next;
      length_count  <= length_count_next;
      volume        <= volume_next;
      force_tq      <= force_tq_next;
      freq          <= freq_next;
      length_en     <= length_en_next;
    end
  end

  // wave memory: cleared by reset, one byte written per wave write event
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WAVE_DEPTH; i++) begin
        wave_mem[i] <= 8'd0;
      end
    end else if (step && (in_action == ACT_WAVE_WR)) begin
      wave_mem[in_addr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= {3'b000, bank_sel_next, freq_next, channel_on_next, sample};
    end
  end

  // checks
  `WSC_ASSERT_NOW(a_skid_full_blocks, in_valid && out_valid && !m_tready, !s_tready,
    "input taken while both stages are full")
  `WSC_ASSERT_NEXT(a_disable_stops, step && (in_action == ACT_DISABLE),
    !channel_on && (length_count == 8'd0), "disable left the channel running")
  `WSC_ASSERT_NEXT(a_trigger_starts,
    step && (in_action == ACT_REG_WR) && (in_sel == REG_FREQ_CTRL) && in_data[7],
    channel_on && (position == '0), "trigger did not restart playback")
  `WSC_ASSERT_NEXT(a_silent_tick, step && (in_action == ACT_TICK) && !(channel_on && dac_on),
    nibble == 4'd0, "tick with channel or dac off fetched a sample")
  `WSC_ASSERT_NEXT(a_result_follows_step, step, m_tvalid,
    "processed event produced no result")

endmodule
